FILE: hw/rtl/prelu_forward_backward_unit_assert.svh
// ---------------------------------------------------------------------------
// prelu_forward_backward_unit assertion macros
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef PRELU_FORWARD_BACKWARD_UNIT_ASSERT_SVH
`define PRELU_FORWARD_BACKWARD_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PFB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfb: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfb: next-cycle check failed");

`endif

FILE: hw/rtl/pfb_pkg.sv
// ---------------------------------------------------------------------------
// pfb_pkg
// Types and constants of the PReLU forward/backward unit.
// ---------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  localparam int DATA_WIDTH       = 16;
  localparam int SLOPE_WIDTH      = 16;
  localparam int SLOPE_FRAC_BITS  = 14;
  localparam int GRAD_WIDTH       = 48;
  localparam int CH_WIDTH         = 6;
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int PROD_WIDTH       = DATA_WIDTH + SLOPE_WIDTH;
  localparam int CFG_WIDTH        = 32;
  localparam int CFG_ADDR_WIDTH   = 5;

  // 0.25 in Q2.14
  localparam logic signed [SLOPE_WIDTH-1:0] SLOPE_RESET =
    SLOPE_WIDTH'(1 << (SLOPE_FRAC_BITS - 2));

  typedef enum logic [1:0] {
    CMD_LOAD_SLOPE = 2'd0,
    CMD_FORWARD    = 2'd1,
    CMD_BACKWARD   = 2'd2,
    CMD_READ_GRAD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SINGLE_SLOPE    = 3'd0,
    REG_CHANNELS_IN_USE = 3'd1,
    REG_INNER_SIZE      = 3'd2,
    REG_EMIT_DX         = 3'd3,
    REG_ACCUM_GRAD      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t                          command;
    logic signed [DATA_WIDTH-1:0]  sample;
    logic signed [DATA_WIDTH-1:0]  upstream_grad;
    logic signed [SLOPE_WIDTH-1:0] slope_value;
    logic [CH_WIDTH-1:0]           channel_select;
    logic                          last;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  value;
    logic signed [GRAD_WIDTH-1:0]  gradient;
    logic                          on_negative_side;
    logic [CH_WIDTH-1:0]           channel_used;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prelu_forward_backward_unit.sv
// ---------------------------------------------------------------------------
// prelu_forward_backward_unit
// Streaming fixed-point PReLU, forward and backward, per-channel slopes.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one command per transfer: load slope,
//   forward element, backward element or read gradient. rsp channel
//   (valid/ready) returns exactly one result per request, in order.
//   User writes registers over the APB port only while the unit is idle; not enforced.
// Timing:
//   One request per cycle sustained while rsp_ready stays high. rsp_valid rises
//   after the request transfer has passed three register stages: slope/gradient
//   memory read, multiplier stage, output register. Slope and gradient updates are
//   written back at the end of the read stage and forwarded to the next request.
// Reset:
//   rst clears counters, pipeline and per-entry valid bits; every slope
//   reads 0.25 and every gradient reads 0 until written. No clearing pass.
// Stall:
//   When rsp_ready is low the pipeline holds; req_ready drops only once
//   all three stages are full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "prelu_forward_backward_unit_assert.svh"

module prelu_forward_backward_unit
  import pfb_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_WIDTH-1:0]      pwdata,
  output logic [CFG_WIDTH-1:0]      prdata,
  output logic                      pready,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  req_t                      req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rsp_t                      rsp
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SCALED_WIDTH = PROD_WIDTH - SLOPE_FRAC_BITS;

  // configuration
  logic        single_slope;
  logic [6:0]  channels_in_use;
  logic [20:0] inner_size;
  logic        emit_dx;
  logic        accum_grad;
  logic        cfg_write;
  reg_idx_t    cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      single_slope    <= 1'b0;
      channels_in_use <= 7'd1;
      inner_size      <= 21'd1;
      emit_dx         <= 1'b1;
      accum_grad      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_SINGLE_SLOPE:    single_slope    <= pwdata[0];
        REG_CHANNELS_IN_USE: channels_in_use <= pwdata[6:0];
        REG_INNER_SIZE:      inner_size      <= pwdata[20:0];
        REG_EMIT_DX:         emit_dx         <= pwdata[0];
        REG_ACCUM_GRAD:      accum_grad      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SINGLE_SLOPE:    prdata = CFG_WIDTH'(single_slope);
      REG_CHANNELS_IN_USE: prdata = CFG_WIDTH'(channels_in_use);
      REG_INNER_SIZE:      prdata = CFG_WIDTH'(inner_size);
      REG_EMIT_DX:         prdata = CFG_WIDTH'(emit_dx);
      REG_ACCUM_GRAD:      prdata = CFG_WIDTH'(accum_grad);
      default:             prdata = '0;
    endcase
  end

  // pipeline flow control
  logic s1_valid, s2_valid;
  logic out_free, s2_free, s1_free, s1_fire, s2_fire, accept;

  assign out_free  = !rsp_valid || rsp_ready;
  assign s2_free   = !s2_valid || out_free;
  assign s2_fire   = s2_valid && out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign s1_fire   = s1_valid && s2_free;
  assign req_ready = s1_free;
  assign accept    = req_valid && req_ready;

  // element position counters
  logic [19:0]         inner_position;
  logic [CH_WIDTH-1:0] channel_position;
  logic                backward_pass_open;
  logic [6:0]          eff_ch;
  logic [20:0]         inner_lim;
  logic                is_elem, is_bwd;
  logic                inner_wrap, chan_wrap;

  always_comb begin
    eff_ch = channels_in_use;
    if (eff_ch == 7'd0) eff_ch = 7'd1;
    if (32'(eff_ch) > MAX_CHANNELS) eff_ch = 7'(MAX_CHANNELS);
  end

  assign inner_lim  = (inner_size == 21'd0) ? 21'd1 : inner_size;
  assign is_bwd     = (req.command == CMD_BACKWARD);
  assign is_elem    = (req.command == CMD_FORWARD) || is_bwd;
  assign inner_wrap = ({1'b0, inner_position} + 21'd1) >= inner_lim;
  assign chan_wrap  = ({1'b0, channel_position} + 7'd1) >= eff_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_position     <= '0;
      channel_position   <= '0;
      backward_pass_open <= 1'b0;
    end else if (accept && is_elem) begin
      if (req.last) begin
        inner_position     <= '0;
        channel_position   <= '0;
        backward_pass_open <= 1'b0;
      end else begin
        if (is_bwd) backward_pass_open <= 1'b1;
        if (inner_wrap) begin
          inner_position <= '0;
          channel_position <= chan_wrap ? '0 : channel_position + 1'b1;
        end else begin
          inner_position <= inner_position + 1'b1;
        end
      end
    end
  end

  // read address
  logic [CH_WIDTH-1:0]          rd_chan;
  logic [AW-1:0]                rd_addr;
  logic                         rd_ok;
  logic signed [PROD_WIDTH-1:0] dyx;

  assign rd_chan = is_elem ? (single_slope ? '0 : channel_position) : req.channel_select;
  assign rd_addr = AW'(rd_chan);
  assign rd_ok   = is_elem || (32'(req.channel_select) < MAX_CHANNELS);
  assign dyx     = req.upstream_grad * req.sample;

  // state memories
  logic signed [SLOPE_WIDTH-1:0] slope_mem [MAX_CHANNELS];
  logic signed [GRAD_WIDTH-1:0]  grad_mem  [MAX_CHANNELS];
  logic signed [SLOPE_WIDTH-1:0] slope_q;
  logic signed [GRAD_WIDTH-1:0]  grad_q;
  logic                          slope_we, grad_we, grad_clear;
  logic signed [GRAD_WIDTH-1:0]  grad_new;

  // stage 1 payload
  cmd_t                          s1_cmd;
  logic signed [DATA_WIDTH-1:0]  s1_x, s1_dy;
  logic signed [SLOPE_WIDTH-1:0] s1_sv;
  logic [AW-1:0]                 s1_addr;
  logic [CH_WIDTH-1:0]           s1_chan;
  logic                          s1_ok, s1_pass_start;
  logic signed [PROD_WIDTH-1:0]  s1_dyx;

  always_ff @(posedge clk) begin
    if (accept) begin
      slope_q <= slope_mem[rd_addr];
      grad_q  <= grad_mem[rd_addr];
    end
    if (slope_we) slope_mem[s1_addr] <= s1_sv;
    if (grad_we) grad_mem[s1_addr] <= grad_new;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd        <= req.command;
      s1_x          <= req.sample;
      s1_dy         <= req.upstream_grad;
      s1_sv         <= req.slope_value;
      s1_addr       <= rd_addr;
      s1_chan       <= rd_chan;
      s1_ok         <= rd_ok;
      s1_pass_start <= is_bwd && !backward_pass_open;
      s1_dyx        <= dyx;
    end
  end

  // valid bits and write-back forwarding
  logic [MAX_CHANNELS-1:0]       svalid, gvalid;
  logic                          sfwd_valid, gfwd_valid;
  logic [AW-1:0]                 sfwd_addr, gfwd_addr;
  logic signed [SLOPE_WIDTH-1:0] sfwd_data;
  logic signed [GRAD_WIDTH-1:0]  gfwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      svalid     <= '0;
      gvalid     <= '0;
      sfwd_valid <= 1'b0;
      gfwd_valid <= 1'b0;
    end else begin
      if (slope_we) begin
        svalid[s1_addr] <= 1'b1;
        sfwd_valid      <= 1'b1;
      end
      // a pass-opening element may also write its own entry
      if (grad_clear) begin
        gvalid     <= grad_we ? (MAX_CHANNELS'(1) << s1_addr) : '0;
        gfwd_valid <= grad_we;
      end else if (grad_we) begin
        gvalid[s1_addr] <= 1'b1;
        gfwd_valid      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slope_we) begin
      sfwd_addr <= s1_addr;
      sfwd_data <= s1_sv;
    end
    if (grad_we) begin
      gfwd_addr <= s1_addr;
      gfwd_data <= grad_new;
    end
  end

  // stage 1: operand select, multiply, gradient update
  logic signed [SLOPE_WIDTH-1:0]  slope_op;
  logic signed [GRAD_WIDTH-1:0]   grad_op;
  logic                           s1_neg, s1_clear;
  logic signed [DATA_WIDTH-1:0]   mult_a;
  logic signed [PROD_WIDTH-1:0]   prod;
  logic signed [GRAD_WIDTH:0]     gsum;

  assign s1_clear = (s1_cmd == CMD_BACKWARD) && s1_pass_start && accum_grad;

  always_comb begin
    if (sfwd_valid && (sfwd_addr == s1_addr)) slope_op = sfwd_data;
    else if (svalid[s1_addr]) slope_op = slope_q;
    else slope_op = SLOPE_RESET;

    if (s1_clear) grad_op = '0;
    else if (gfwd_valid && (gfwd_addr == s1_addr)) grad_op = gfwd_data;
    else if (gvalid[s1_addr]) grad_op = grad_q;
    else grad_op = '0;

    case (s1_cmd)
      CMD_FORWARD:  s1_neg = (s1_x < 0);
      CMD_BACKWARD: s1_neg = (s1_x <= 0);
      default:      s1_neg = 1'b0;
    endcase
  end

  assign mult_a = (s1_cmd == CMD_FORWARD) ? s1_x : s1_dy;
  assign prod   = mult_a * slope_op;
  assign gsum   = (GRAD_WIDTH+1)'(grad_op) + (GRAD_WIDTH+1)'(s1_dyx);

  always_comb begin
    if (gsum[GRAD_WIDTH] != gsum[GRAD_WIDTH-1])
      grad_new = gsum[GRAD_WIDTH] ? {1'b1, {(GRAD_WIDTH-1){1'b0}}}
                                  : {1'b0, {(GRAD_WIDTH-1){1'b1}}};
    else
      grad_new = gsum[GRAD_WIDTH-1:0];
  end

  assign slope_we   = s1_fire && (s1_cmd == CMD_LOAD_SLOPE) && s1_ok;
  assign grad_we    = s1_fire && (s1_cmd == CMD_BACKWARD) && s1_neg && accum_grad;
  assign grad_clear = s1_fire && s1_clear;

  // stage 2 payload
  cmd_t                         s2_cmd;
  logic signed [DATA_WIDTH-1:0] s2_x, s2_dy;
  logic signed [PROD_WIDTH-1:0] s2_prod;
  logic                         s2_neg;
  logic [CH_WIDTH-1:0]          s2_chan;
  logic signed [GRAD_WIDTH-1:0] s2_grad;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_cmd  <= s1_cmd;
      s2_x    <= s1_x;
      s2_dy   <= s1_dy;
      s2_prod <= prod;
      s2_neg  <= s1_neg;
      s2_chan <= s1_chan;
      s2_grad <= ((s1_cmd == CMD_READ_GRAD) && s1_ok) ? grad_op : '0;
    end
  end

  // stage 2: floor scale and saturate
  logic signed [SCALED_WIDTH-1:0] scaled;
  logic signed [DATA_WIDTH-1:0]   scaled_sat;
  logic signed [DATA_WIDTH-1:0]   value_next;
  logic                           upper_ones, upper_zeros;

  assign scaled      = SCALED_WIDTH'(s2_prod >>> SLOPE_FRAC_BITS);
  assign upper_ones  = &scaled[SCALED_WIDTH-1:DATA_WIDTH-1];
  assign upper_zeros = ~|scaled[SCALED_WIDTH-1:DATA_WIDTH-1];

  always_comb begin
    if (upper_ones || upper_zeros)
      scaled_sat = scaled[DATA_WIDTH-1:0];
    else if (scaled[SCALED_WIDTH-1])
      scaled_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    else
      scaled_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    case (s2_cmd)
      CMD_FORWARD:  value_next = s2_neg ? scaled_sat : s2_x;
      CMD_BACKWARD: value_next = !emit_dx ? '0 : (s2_neg ? scaled_sat : s2_dy);
      default:      value_next = '0;
    endcase
  end

  // pipeline valids and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_fire) s1_valid <= 1'b0;
      if (s1_fire) s2_valid <= 1'b1;
      else if (s2_fire) s2_valid <= 1'b0;
      if (s2_fire) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      rsp.value            <= value_next;
      rsp.gradient         <= s2_grad;
      rsp.on_negative_side <= s2_neg;
      rsp.channel_used     <= s2_chan;
    end
  end

  `PFB_ASSERT_NEXT(a_last_resets_pos, clk, rst, accept && is_elem && req.last, (inner_position == '0) && (channel_position == '0) && !backward_pass_open)
  `PFB_ASSERT_NEXT(a_s2_holds, clk, rst, s2_valid && !out_free, s2_valid && $stable(s2_prod) && $stable(s2_grad))
  `PFB_ASSERT_NEXT(a_grad_write_valid, clk, rst, grad_we, gvalid[$past(s1_addr)] && gfwd_valid)

endmodule

`default_nettype wire

FILE: sim/prelu_forward_backward_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prelu_forward_backward_checker
// Follows the register port and both streams of the PReLU unit. Every
// request transfer is run through a local copy of the slope table, the
// gradient table and the position counters. The result is queued and
// compared field by field with the response transfers, in order.
// ---------------------------------------------------------------------------
module prelu_forward_backward_checker
  import pfb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_WIDTH-1:0]      pwdata,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  req_t                      req,
  input  logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  rsp_t                      rsp,
  output int                        mismatch_count,
  output int                        pending_count
);

  localparam int     NUM_CH  = MAX_CHANNELS_DEF;
  localparam longint DATA_HI = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint GRAD_HI = (longint'(1) <<< (GRAD_WIDTH - 1)) - 1;

  logic signed [SLOPE_WIDTH-1:0] slope_mem [NUM_CH];
  logic signed [GRAD_WIDTH-1:0]  grad_mem  [NUM_CH];
  logic [19:0]                   inner_pos;
  logic [CH_WIDTH-1:0]           chan_pos;
  logic                          bwd_open;

  logic                          cfg_shared;
  logic [6:0]                    cfg_channels;
  logic [20:0]                   cfg_inner;
  logic                          cfg_emit_dx;
  logic                          cfg_accum_grad;

  rsp_t result_q [$];
  int   fail_count  = 0;
  int   outstanding = 0;

  assign mismatch_count = fail_count;
  assign pending_count  = outstanding;

  function automatic longint clamp(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // One element through the unit; updates tables and counters.
  function automatic rsp_t predict_prelu(req_t r);
    rsp_t                e;
    longint              x;
    longint              dy;
    longint              slope;
    int unsigned         eff_inner;
    int unsigned         eff_ch;
    logic [CH_WIDTH-1:0] ch;
    e = '0;
    e.channel_used = r.channel_select;
    x  = $signed(r.sample);
    dy = $signed(r.upstream_grad);
    case (r.command)
      CMD_LOAD_SLOPE: slope_mem[r.channel_select] = r.slope_value;
      CMD_READ_GRAD:  e.gradient = grad_mem[r.channel_select];
      default: begin
        ch = cfg_shared ? '0 : chan_pos;
        slope = $signed(slope_mem[ch]);
        e.channel_used = ch;
        if (r.command == CMD_FORWARD) begin
          if (x >= 0) begin
            e.value = r.sample;
          end else begin
            e.on_negative_side = 1'b1;
            e.value = DATA_WIDTH'(clamp((slope * x) >>> SLOPE_FRAC_BITS, DATA_HI));
          end
        end else begin
          // first backward element of a pass
          if (!bwd_open) begin
            if (cfg_accum_grad) begin
              foreach (grad_mem[i]) grad_mem[i] = '0;
            end
            bwd_open = 1'b1;
          end
          if (x > 0) begin
            e.value = r.upstream_grad;
          end else begin
            e.on_negative_side = 1'b1;
            e.value = DATA_WIDTH'(clamp((dy * slope) >>> SLOPE_FRAC_BITS, DATA_HI));
            if (cfg_accum_grad) begin
              grad_mem[ch] = GRAD_WIDTH'(clamp($signed(grad_mem[ch]) + dy * x, GRAD_HI));
            end
          end
          if (!cfg_emit_dx) e.value = '0;
        end
        // position counters
        eff_inner = (cfg_inner == 0) ? 1 : cfg_inner;
        eff_ch = (cfg_channels == 0) ? 1 : cfg_channels;
        if (eff_ch > NUM_CH) eff_ch = NUM_CH;
        if (r.last) begin
          inner_pos = '0;
          chan_pos  = '0;
          bwd_open  = 1'b0;
        end else if (inner_pos + 1 >= eff_inner) begin
          inner_pos = '0;
          if (chan_pos + 1 >= eff_ch) chan_pos = '0;
          else chan_pos = chan_pos + 1'b1;
        end else begin
          inner_pos = inner_pos + 1'b1;
        end
      end
    endcase
    return e;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      foreach (slope_mem[i]) slope_mem[i] = SLOPE_RESET;
      foreach (grad_mem[i]) grad_mem[i] = '0;
      inner_pos      = '0;
      chan_pos       = '0;
      bwd_open       = 1'b0;
      cfg_shared     = 1'b0;
      cfg_channels   = 7'd1;
      cfg_inner      = 21'd1;
      cfg_emit_dx    = 1'b1;
      cfg_accum_grad = 1'b1;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_WIDTH-1:2])
          REG_SINGLE_SLOPE:    cfg_shared     = pwdata[0];
          REG_CHANNELS_IN_USE: cfg_channels   = pwdata[6:0];
          REG_INNER_SIZE:      cfg_inner      = pwdata[20:0];
          REG_EMIT_DX:         cfg_emit_dx    = pwdata[0];
          REG_ACCUM_GRAD:      cfg_accum_grad = pwdata[0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response with nothing outstanding: value %0d gradient %0d",
                     $realtime, rsp.value, rsp.gradient);
        end else begin
          exp_rsp = result_q.pop_front();
          if (rsp.value !== exp_rsp.value || rsp.gradient !== exp_rsp.gradient ||
              rsp.on_negative_side !== exp_rsp.on_negative_side ||
              rsp.channel_used !== exp_rsp.channel_used) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: exp/got value %0d/%0d grad %0d/%0d neg %0b/%0b chan %0d/%0d",
                       $realtime,
                       exp_rsp.value, rsp.value, exp_rsp.gradient, rsp.gradient,
                       exp_rsp.on_negative_side, rsp.on_negative_side,
                       exp_rsp.channel_used, rsp.channel_used);
          end
        end
      end
      if (req_valid && req_ready) result_q.push_back(predict_prelu(req));
    end
    outstanding = result_q.size();
  end

endmodule

FILE: sim/tb_prelu_forward_backward_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_prelu_forward_backward_unit
// Drives the PReLU unit with directed corner elements, a gradient
// accumulation run on two channels, and random tensor passes under a range
// of register settings, with random idle cycles on both streams.
// ---------------------------------------------------------------------------
module tb_prelu_forward_backward_unit;
  import pfb_pkg::*;

  localparam int RANDOM_ITEMS   = 975;
  localparam int PHASE_ITEMS    = 75;
  localparam int ACCUM_ELEMENTS = 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

  typedef enum int {GAP_NONE, GAP_SOME, GAP_FULL} gap_mode_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      psel      = 1'b0;
  logic                      penable   = 1'b0;
  logic                      pwrite    = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr     = '0;
  logic [CFG_WIDTH-1:0]      pwdata    = '0;
  logic [CFG_WIDTH-1:0]      prdata;
  logic                      pready;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  req_t                      req       = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  rsp_t                      rsp;

  int        mismatch_count;
  int        pending_count;
  int        items_sent        = 0;
  int        quiet_cycles      = 0;
  bit        long_hold_request = 1'b0;
  gap_mode_t send_mode         = GAP_SOME;
  gap_mode_t recv_mode         = GAP_SOME;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prelu_forward_backward_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  prelu_forward_backward_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  function automatic int draw_gap(gap_mode_t m);
    case (m)
      GAP_NONE: return 0;
      GAP_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      default:  return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      4:       return DATA_WIDTH'(1);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  function automatic req_t mk(cmd_t c, logic [DATA_WIDTH-1:0] x, logic [DATA_WIDTH-1:0] dy,
                              logic [SLOPE_WIDTH-1:0] sl, logic [CH_WIDTH-1:0] sel,
                              logic lst);
    req_t r;
    r.command        = c;
    r.sample         = x;
    r.upstream_grad  = dy;
    r.slope_value    = sl;
    r.channel_select = sel;
    r.last           = lst;
    return r;
  endfunction

  function automatic req_t random_req(cmd_t c, logic lst);
    return mk(c, pick_word(), pick_word(), pick_word(), CH_WIDTH'($urandom), lst);
  endfunction

  // All tasks start and end just after a falling edge.
  task automatic send_item(req_t item);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = item;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [CFG_WIDTH-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(bit shared, logic [6:0] chans, logic [20:0] inner,
                            bit pdown, bit pslope);
    drain();
    apb_write(REG_SINGLE_SLOPE, CFG_WIDTH'(shared));
    apb_write(REG_CHANNELS_IN_USE, CFG_WIDTH'(chans));
    apb_write(REG_INNER_SIZE, CFG_WIDTH'(inner));
    apb_write(REG_EMIT_DX, CFG_WIDTH'(pdown));
    apb_write(REG_ACCUM_GRAD, CFG_WIDTH'(pslope));
  endtask

  // Response side: per-result stall, plus one long hold-off on request.
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        rsp_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        rsp_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_prelu_forward_backward_unit: errors");
      $finish;
    end
  end

  initial begin
    int          phase;
    int          random_base;
    int          phase_end;
    int          plen;
    bit          mixed;
    cmd_t        dir;
    cmd_t        cmd;
    bit          c_shared;
    logic [6:0]  c_chans;
    logic [20:0] c_inner;
    bit          c_pdown;
    bit          c_pslope;
    longint      tensor;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // corner elements under reset settings
    send_item(mk(CMD_READ_GRAD, '0, '0, '0, '0, 1'b0));
    send_item(mk(CMD_FORWARD, WORD_MAX, '0, '0, '0, 1'b0));
    send_item(mk(CMD_FORWARD, '0, WORD_MAX, '0, '1, 1'b0));
    send_item(mk(CMD_FORWARD, WORD_MIN, '0, '0, '0, 1'b0));
    send_item(mk(CMD_LOAD_SLOPE, '0, '0, WORD_MIN, '0, 1'b1));
    send_item(mk(CMD_FORWARD, WORD_MIN, '0, '0, '0, 1'b0));
    send_item(mk(CMD_LOAD_SLOPE, '0, '0, WORD_MAX, '0, 1'b0));
    send_item(mk(CMD_FORWARD, WORD_MIN, '0, '0, '0, 1'b0));
    send_item(mk(CMD_FORWARD, '1, '0, '0, '0, 1'b0));
    // backward pass: opening clears the gradients, zero input takes the slope
    send_item(mk(CMD_BACKWARD, '0, WORD_MAX, '0, '0, 1'b0));
    send_item(mk(CMD_BACKWARD, DATA_WIDTH'(1), WORD_MIN, '0, '0, 1'b0));
    send_item(mk(CMD_BACKWARD, WORD_MIN, WORD_MIN, '0, '0, 1'b0));
    send_item(mk(CMD_BACKWARD, WORD_MIN, WORD_MAX, '0, '0, 1'b1));
    send_item(mk(CMD_READ_GRAD, '0, '0, '0, '0, 1'b1));
    send_item(mk(CMD_BACKWARD, '1, DATA_WIDTH'(5), '0, '0, 1'b0));
    send_item(mk(CMD_READ_GRAD, '0, '0, '0, '0, 1'b0));
    send_item(mk(CMD_LOAD_SLOPE, '0, '0, SLOPE_WIDTH'(16'h2000), '1, 1'b0));
    send_item(mk(CMD_READ_GRAD, '0, '0, '0, '1, 1'b0));
    send_item(mk(CMD_FORWARD, '1, '0, '0, '0, 1'b1));

    // back-to-back accumulation on two channels with opposite signs
    set_config(1'b0, 7'd2, 21'd1, 1'b1, 1'b1);
    send_mode = GAP_NONE;
    recv_mode = GAP_NONE;
    for (int i = 0; i < 2 * ACCUM_ELEMENTS; i++) begin
      send_item(mk(CMD_BACKWARD, WORD_MIN, (i % 2 == 0) ? WORD_MIN : WORD_MAX, '0, '0,
                   i == 2 * ACCUM_ELEMENTS - 1));
    end
    send_item(mk(CMD_READ_GRAD, '0, '0, '0, CH_WIDTH'(0), 1'b0));
    send_item(mk(CMD_READ_GRAD, '0, '0, '0, CH_WIDTH'(1), 1'b0));

    // random tensor passes, one register setting per phase
    phase = 0;
    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      case (phase)
        0: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b0, 7'd1, 21'd1, 2'b11};
        1: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b0, 7'd64, 21'd1, 2'b11};
        2: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b0, 7'd64, 21'd3, 2'b01};
        3: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b1, 7'd5, 21'd2, 2'b10};
        4: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b0, 7'd0, 21'd0, 2'b11};
        5: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b0, 7'd127, 21'd1, 2'b10};
        6: {c_shared, c_chans, c_inner, c_pdown, c_pslope} = {1'b0, 7'd7, 21'd1048576, 2'b11};
        default: begin
          c_shared = 1'($urandom_range(0, 1));
          c_chans = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(1, 8));
          case ($urandom_range(0, 3))
            0:       c_inner = 21'd1048576;
            1:       c_inner = 21'($urandom_range(0, 1048576));
            default: c_inner = 21'($urandom_range(0, 6));
          endcase
          c_pdown  = 1'($urandom_range(0, 1));
          c_pslope = 1'($urandom_range(0, 1));
        end
      endcase
      set_config(c_shared, c_chans, c_inner, c_pdown, c_pslope);
      send_mode = gap_mode_t'($urandom_range(0, 2));
      recv_mode = gap_mode_t'($urandom_range(0, 2));
      if (phase == 1 || phase == 9) begin
        // output held off while input keeps coming: the unit must back up
        send_mode = GAP_NONE;
        long_hold_request = 1'b1;
      end
      tensor = longint'((c_inner == 0) ? 1 : c_inner) *
               ((c_chans == 0) ? 1 : (c_chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : c_chans);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        plen  = (tensor <= 48) ? int'(tensor) : $urandom_range(4, 40);
        if ($urandom_range(0, 7) == 0) plen = $urandom_range(1, 20);
        mixed = ($urandom_range(0, 7) == 0);
        dir   = $urandom_range(0, 1) ? CMD_FORWARD : CMD_BACKWARD;
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            cmd = $urandom_range(0, 1) ? CMD_LOAD_SLOPE : CMD_READ_GRAD;
            send_item(random_req(cmd, 1'($urandom_range(0, 1))));
          end
          cmd = mixed ? ($urandom_range(0, 1) ? CMD_FORWARD : CMD_BACKWARD) : dir;
          send_item(random_req(cmd, i == plen - 1));
        end
      end
      phase++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_prelu_forward_backward_unit: clean");
    end else begin
      $display("tb_prelu_forward_backward_unit: errors");
    end
    $finish;
  end

endmodule
